@@ rtl/core/amts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amts_pkg
// Shared types, constants and the sine table builder for the AM tone
// synthesizer core.
// ----------------------------------------------------------------------------
package amts_pkg;

    localparam int TAB_BITS       = 10;
    localparam int QUARTER        = 1 << (TAB_BITS - 2);
    localparam int QIDX_BITS      = TAB_BITS - 1;
    localparam int MAG_BITS       = 15;
    localparam int PROD_BITS      = 2 * MAG_BITS;
    localparam int GAIN_BITS      = 24;
    localparam int STEP_BITS      = 32;
    localparam int CNT_BITS       = 4;
    localparam int CH_BITS        = 3;
    localparam int SAMPLE_BITS    = 16;
    localparam int MUL_BITS       = PROD_BITS + GAIN_BITS;
    localparam int GAIN_SHIFT     = 38;
    localparam int PC_BITS        = 3;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [63:0]          HALF_PI_Q30    = 64'd1686629713;
    localparam logic [CNT_BITS-1:0]  C_MAX_CHANNELS = 4'd8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CARRIER_STEP  = 2'd0,
        CFG_MOD_STEP      = 2'd1,
        CFG_GAIN          = 2'd2,
        CFG_CHANNEL_COUNT = 2'd3
    } t_cfg_idx;

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_RDC,
        OP_RDM,
        OP_MUL_SINE,
        OP_MUL_GAIN,
        OP_SAT,
        OP_EMIT
    } t_op;

    // jump condition: jump to target when true, else fall through
    typedef enum logic [2:0] {
        C_NEXT,
        C_WAIT_IN,
        C_ZERO_CH,
        C_EMIT,
        C_ALWAYS
    } t_cond;

    typedef struct packed {
        t_op                 op;
        t_cond               cond;
        logic [PC_BITS-1:0]  target;
    } t_ctl;

    typedef struct packed {
        logic in_fire;
        logic ch_zero;
        logic emit_load;
        logic emit_last;
    } t_status;

    typedef logic [QUARTER:0][MAG_BITS-1:0] t_qtab;

    // sin(pi/2 * q / QUARTER) in Q15, Q30 Taylor series up to x^11
    function automatic logic [MAG_BITS-1:0] f_quarter_sine(input int unsigned q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      s;
        x = (64'(q) * HALF_PI_Q30) >> (TAB_BITS - 2);
        x2 = (x * x) >> 30;
        t = x;
        s = longint'(x);
        t = ((t * x2) >> 30) / 6;
        s = s - longint'(t);
        t = ((t * x2) >> 30) / 20;
        s = s + longint'(t);
        t = ((t * x2) >> 30) / 42;
        s = s - longint'(t);
        t = ((t * x2) >> 30) / 72;
        s = s + longint'(t);
        t = ((t * x2) >> 30) / 110;
        s = s - longint'(t);
        if (s < 0) begin
            s = 0;
        end
        s = (s + 16384) >>> 15;
        if (s > 32767) begin
            s = 32767;
        end
        return MAG_BITS'(s);
    endfunction

    function automatic t_qtab f_build_qtab();
        t_qtab tab;
        for (int i = 0; i <= QUARTER; i++) begin
            tab[i] = f_quarter_sine(i);
        end
        return tab;
    endfunction

endpackage

@@ rtl/core/amts_sine_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amts_sine_rom
// Quarter-wave sine lookup with registered output: magnitude in Q15 and
// sign, folded from the top table address bits.
// ----------------------------------------------------------------------------
module amts_sine_rom (
    input  logic                          i_clk,
    input  logic [amts_pkg::TAB_BITS-1:0] i_addr,
    output logic [amts_pkg::MAG_BITS-1:0] o_mag,
    output logic                          o_neg
);

    localparam amts_pkg::t_qtab QTAB = amts_pkg::f_build_qtab();

    logic [1:0]                         quad;
    logic [amts_pkg::TAB_BITS-3:0]      r_off;
    logic [amts_pkg::QIDX_BITS-1:0]     qidx;

    assign quad  = i_addr[amts_pkg::TAB_BITS-1 -: 2];
    assign r_off = i_addr[amts_pkg::TAB_BITS-3:0];
    assign qidx  = quad[0] ? (amts_pkg::QIDX_BITS'(amts_pkg::QUARTER)
                              - amts_pkg::QIDX_BITS'(r_off))
                           : amts_pkg::QIDX_BITS'(r_off);

    always_ff @(posedge i_clk) begin
        o_mag <= QTAB[qidx];
        o_neg <= quad[1];
    end

endmodule

@@ rtl/core/amts_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amts_sequencer
// Step counter and microcode ROM. Each step issues one control word to the
// datapath and picks the next step from the datapath status.
// ----------------------------------------------------------------------------
module amts_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  amts_pkg::t_status i_status,
    output amts_pkg::t_ctl    o_ctl
);

    localparam logic [amts_pkg::PC_BITS-1:0] S_IDLE = 3'd0;
    localparam logic [amts_pkg::PC_BITS-1:0] S_RDC  = 3'd1;
    localparam logic [amts_pkg::PC_BITS-1:0] S_EMIT = 3'd6;
    localparam int                           N_STEPS = 8;

    localparam amts_pkg::t_ctl PROG [0:N_STEPS-1] = '{
        '{op: amts_pkg::OP_LOAD,     cond: amts_pkg::C_WAIT_IN, target: S_IDLE},
        '{op: amts_pkg::OP_RDC,      cond: amts_pkg::C_NEXT,    target: S_IDLE},
        '{op: amts_pkg::OP_RDM,      cond: amts_pkg::C_NEXT,    target: S_IDLE},
        '{op: amts_pkg::OP_MUL_SINE, cond: amts_pkg::C_NEXT,    target: S_IDLE},
        '{op: amts_pkg::OP_MUL_GAIN, cond: amts_pkg::C_NEXT,    target: S_IDLE},
        '{op: amts_pkg::OP_SAT,      cond: amts_pkg::C_ZERO_CH, target: S_IDLE},
        '{op: amts_pkg::OP_EMIT,     cond: amts_pkg::C_EMIT,    target: S_EMIT},
        '{op: amts_pkg::OP_NOP,      cond: amts_pkg::C_ALWAYS,  target: S_IDLE}
    };

    logic [amts_pkg::PC_BITS-1:0] r_pc;
    logic [amts_pkg::PC_BITS-1:0] n_pc;
    logic                         take;

    assign o_ctl = PROG[r_pc];

    always_comb begin
        unique case (o_ctl.cond)
            amts_pkg::C_NEXT:    take = 1'b0;
            amts_pkg::C_WAIT_IN: take = !i_status.in_fire;
            amts_pkg::C_ZERO_CH: take = i_status.ch_zero;
            amts_pkg::C_EMIT:    take = !(i_status.emit_load && i_status.emit_last);
            amts_pkg::C_ALWAYS:  take = 1'b1;
            default:             take = 1'b0;
        endcase
        n_pc = take ? o_ctl.target : r_pc + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.in_fire |=> r_pc == S_RDC)
        else $error("accepted request did not start the program");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.op == amts_pkg::OP_EMIT && !i_status.emit_load) |=> r_pc == S_EMIT)
        else $error("emit step left while output stalled");

endmodule

@@ rtl/core/amts_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amts_datapath
// Phase accumulators, shared sine lookup, shared 30x24 multiplier,
// saturation and the channel copy output register.
// ----------------------------------------------------------------------------
module amts_datapath #(
    parameter int PHASE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  amts_pkg::t_ctl                       i_ctl,
    output amts_pkg::t_status                    o_status,
    input  logic [amts_pkg::STEP_BITS-1:0]       i_carrier_step,
    input  logic [amts_pkg::STEP_BITS-1:0]       i_mod_step,
    input  logic [amts_pkg::GAIN_BITS-1:0]       i_gain,
    input  logic [amts_pkg::CNT_BITS-1:0]        i_channel_count,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_restart,
    output logic                                 o_s_tready,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [amts_pkg::SAMPLE_BITS-1:0]     o_sample,
    output logic [amts_pkg::CH_BITS-1:0]         o_channel,
    output logic                                 o_last
);

    localparam int MB = amts_pkg::MAG_BITS;
    localparam int PB = amts_pkg::PROD_BITS;
    localparam int GB = amts_pkg::GAIN_BITS;
    localparam int UB = amts_pkg::MUL_BITS;
    localparam int SB = amts_pkg::SAMPLE_BITS;

    logic [PHASE_BITS-1:0]              r_car_phase;
    logic [PHASE_BITS-1:0]              r_mod_phase;
    logic [MB-1:0]                      r_sc_mag;
    logic                               r_sc_neg;
    logic                               r_neg;
    logic [UB-1:0]                      r_prod;
    logic [SB-1:0]                      r_sample;
    logic [amts_pkg::CH_BITS-1:0]       r_ch;
    logic                               r_out_valid;

    logic [amts_pkg::TAB_BITS-1:0]      rom_addr;
    logic [MB-1:0]                      rom_mag;
    logic                               rom_neg;
    logic [PB-1:0]                      mul_a;
    logic [GB-1:0]                      mul_b;
    logic [UB-1:0]                      mul_p;
    logic [SB-1:0]                      q;
    logic [SB-1:0]                      sat;
    logic [amts_pkg::CNT_BITS-1:0]      n_eff;
    logic                               in_fire;
    logic                               out_free;
    logic                               emit_load;
    logic                               emit_last;

    amts_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_mag  (rom_mag),
        .o_neg  (rom_neg)
    );

    assign rom_addr = (i_ctl.op == amts_pkg::OP_RDM)
                    ? r_mod_phase[PHASE_BITS-1 -: amts_pkg::TAB_BITS]
                    : r_car_phase[PHASE_BITS-1 -: amts_pkg::TAB_BITS];

    assign o_s_tready = (i_ctl.op == amts_pkg::OP_LOAD);
    assign in_fire    = i_s_tvalid && o_s_tready;

    // first pass: |sin_c| * |sin_m|, second pass: product * gain
    assign mul_a = (i_ctl.op == amts_pkg::OP_MUL_SINE) ? PB'(r_sc_mag) : r_prod[PB-1:0];
    assign mul_b = (i_ctl.op == amts_pkg::OP_MUL_SINE) ? GB'(rom_mag) : i_gain;
    assign mul_p = UB'(mul_a) * UB'(mul_b);

    assign q = r_prod[amts_pkg::GAIN_SHIFT +: SB];
    always_comb begin
        if (r_neg) begin
            sat = (q > 16'h8000) ? 16'h8000 : 16'(-q);
        end else begin
            sat = (q > 16'h7fff) ? 16'h7fff : q;
        end
    end

    assign n_eff     = (i_channel_count > amts_pkg::C_MAX_CHANNELS)
                     ? amts_pkg::C_MAX_CHANNELS : i_channel_count;
    assign out_free  = !r_out_valid || i_m_tready;
    assign emit_load = (i_ctl.op == amts_pkg::OP_EMIT) && out_free;
    assign emit_last = (amts_pkg::CNT_BITS'(r_ch) + 4'd1) == n_eff;

    assign o_status.in_fire   = in_fire;
    assign o_status.ch_zero   = (n_eff == '0);
    assign o_status.emit_load = emit_load;
    assign o_status.emit_last = emit_last;
    assign o_m_tvalid         = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_phase <= '0;
            r_mod_phase <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire && i_restart) begin
                r_car_phase <= '0;
                r_mod_phase <= '0;
            end else if (i_ctl.op == amts_pkg::OP_MUL_GAIN) begin
                r_car_phase <= r_car_phase + PHASE_BITS'(i_carrier_step);
                r_mod_phase <= r_mod_phase + PHASE_BITS'(i_mod_step);
            end
            if (in_fire) begin
                r_ch <= '0;
            end else if (emit_load) begin
                r_ch <= r_ch + 3'd1;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == amts_pkg::OP_RDM) begin
            r_sc_mag <= rom_mag;
            r_sc_neg <= rom_neg;
        end
        if (i_ctl.op == amts_pkg::OP_MUL_SINE) begin
            r_neg <= r_sc_neg ^ rom_neg;
        end
        if (i_ctl.op == amts_pkg::OP_MUL_SINE || i_ctl.op == amts_pkg::OP_MUL_GAIN) begin
            r_prod <= mul_p;
        end
        if (i_ctl.op == amts_pkg::OP_SAT) begin
            r_sample <= sat;
        end
        if (emit_load) begin
            o_sample  <= r_sample;
            o_channel <= r_ch;
            o_last    <= emit_last;
        end
    end

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_restart) |=> (r_car_phase == '0 && r_mod_phase == '0))
        else $error("restart did not clear phases");

    a_copy_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && r_ch != '0) |=> o_sample == $past(o_sample))
        else $error("channel copy changed sample");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_ctl.op == amts_pkg::OP_EMIT))
        else $error("output valid outside emit step");

endmodule

@@ rtl/core/am_tone_synthesizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// am_tone_synthesizer_core
// Sine oscillator with amplitude modulation, run by a microcoded sequencer.
//
// Usage:
//   Slave stream: one request per audio frame; i_s_tdata[0] = restart
//   zeroes carrier and modulator phase before the frame is computed.
//   Master stream: one request per channel copy of the frame; tdata holds
//   the saturated signed 16-bit sample, tuser the channel index, tlast
//   marks the final copy. A channel count of zero emits nothing.
//   Config port: write-only, i_cfg_idx 0 carrier step, 1 modulator step,
//   2 gain (Q16.8), 3 channel count; write only while idle.
//   Sequence: an accepted request starts the eight-step program, which
//   reads both sines, multiplies, applies gain, saturates and emits, sharing
//   one table port and one multiplier; a new frame is accepted only in its
//   wait step. Copies leave one per cycle while the output register is free.
//   Reset: phases, steps and gain clear, channel count is 1, the program
//   returns to its wait step. A stalled master side holds the current
//   copy; the program waits in its emit step until the register frees.
// ----------------------------------------------------------------------------
module am_tone_synthesizer_core #(
    parameter int PHASE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [amts_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [amts_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [7:0]                           i_s_tdata,  // [0] restart
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [15:0]                          o_m_tdata,  // [15:0] sample
    output logic [2:0]                           o_m_tuser,  // [2:0] channel
    output logic                                 o_m_tlast
);

    logic [amts_pkg::STEP_BITS-1:0] r_carrier_step;
    logic [amts_pkg::STEP_BITS-1:0] r_mod_step;
    logic [amts_pkg::GAIN_BITS-1:0] r_gain;
    logic [amts_pkg::CNT_BITS-1:0]  r_channel_count;

    amts_pkg::t_ctl    ctl;
    amts_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_step  <= '0;
            r_mod_step      <= '0;
            r_gain          <= '0;
            r_channel_count <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (amts_pkg::t_cfg_idx'(i_cfg_idx))
                amts_pkg::CFG_CARRIER_STEP:  r_carrier_step  <= i_cfg_wdata;
                amts_pkg::CFG_MOD_STEP:      r_mod_step      <= i_cfg_wdata;
                amts_pkg::CFG_GAIN:          r_gain          <= i_cfg_wdata[amts_pkg::GAIN_BITS-1:0];
                amts_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_wdata[amts_pkg::CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    amts_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl)
    );

    amts_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_status        (status),
        .i_carrier_step  (r_carrier_step),
        .i_mod_step      (r_mod_step),
        .i_gain          (r_gain),
        .i_channel_count (r_channel_count),
        .i_s_tvalid      (i_s_tvalid),
        .i_restart       (i_s_tdata[0]),
        .o_s_tready      (o_s_tready),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_sample        (o_m_tdata),
        .o_channel       (o_m_tuser),
        .o_last          (o_m_tlast)
    );

endmodule
